### hw/rtl/sgc_pkg.sv
// Shared types and constants for the stick grid cursor autorepeat core.
// Used by the interfaces, the pipeline modules and the top level.
`default_nettype none

package sgc_pkg;

   localparam int GRID_ROWS   = 5;
   localparam int GRID_COLS   = 10;
   localparam int SERVICE_ROW = 4;

   localparam int ROW_W   = 3;
   localparam int COL_W   = 4;
   localparam int DIR_W   = 3;
   localparam int THR_W   = 15;
   localparam int TIME_W  = 20;
   localparam int WAIT_W  = 21;
   localparam int STICK_W = 16;
   localparam int SQ_W    = 31;
   localparam int TSQ_W   = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 3'd0,
      DIR_DOWN  = 3'd1,
      DIR_LEFT  = 3'd2,
      DIR_RIGHT = 3'd3,
      DIR_NONE  = 3'd4
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE     = 3'd0,
      CSR_PRESS_THR  = 3'd1,
      CSR_RELEASE_THR = 3'd2,
      CSR_FIRST_DLY  = 3'd3,
      CSR_REPEAT_DLY = 3'd4
   } csr_idx_type;

   localparam logic [TSQ_W-1:0]  RST_PRESS_SQ   = 30'd268435456;
   localparam logic [TSQ_W-1:0]  RST_RELEASE_SQ = 30'd131537961;
   localparam logic [TIME_W-1:0] RST_FIRST_DLY  = 20'd350000;
   localparam logic [TIME_W-1:0] RST_REPEAT_DLY = 20'd120000;
   localparam logic [ROW_W-1:0]  RST_ROW        = 3'd1;
   localparam logic [COL_W-1:0]  RST_COL        = 4'd0;

   typedef struct packed {
      logic                 enable;
      logic [TSQ_W-1:0]     press_sq;
      logic [TSQ_W-1:0]     release_sq;
      logic [TIME_W-1:0]    first_delay_us;
      logic [TIME_W-1:0]    repeat_delay_us;
   } cfg_type;

   typedef struct packed {
      logic [SQ_W-1:0]   x_sq;
      logic [SQ_W-1:0]   y_sq;
      logic              x_dom;
      logic              x_pos;
      logic              y_pos;
      logic [TIME_W-1:0] elapsed_us;
   } front_type;

endpackage

`default_nettype wire

### hw/rtl/sgc_if.sv
// Valid/ready channel interfaces for the stick samples and the cursor results.
// Depends on sgc_pkg for field widths.
`default_nettype none

interface sgc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sgc_pkg::STICK_W-1:0]  stick_x;
   logic signed [sgc_pkg::STICK_W-1:0]  stick_y;
   logic        [sgc_pkg::TIME_W-1:0]   elapsed_us;

   modport source (output valid, stick_x, stick_y, elapsed_us, input ready);
   modport sink   (input valid, stick_x, stick_y, elapsed_us, output ready);
endinterface

interface sgc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sgc_pkg::ROW_W-1:0]    cursor_row;
   logic [sgc_pkg::COL_W-1:0]    cursor_col;
   logic                         moved;
   logic [sgc_pkg::DIR_W-1:0]    held_direction;

   modport source (output valid, cursor_row, cursor_col, moved, held_direction, input ready);
   modport sink   (input valid, cursor_row, cursor_col, moved, held_direction, output ready);
endinterface

`default_nettype wire

### hw/rtl/sgc_csr.sv
// Configuration registers; the thresholds are kept squared for the magnitude test.
// Depends on sgc_pkg.
`default_nettype none

module sgc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [sgc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sgc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sgc_pkg::cfg_type                        cfg
);

   sgc_pkg::cfg_type             cfg_ff;
   sgc_pkg::cfg_type             cfg_in;
   logic [sgc_pkg::TSQ_W-1:0]    thr_sq;

   assign thr_sq = sgc_pkg::TSQ_W'(csr_wdata[sgc_pkg::THR_W-1:0]) *
                   sgc_pkg::TSQ_W'(csr_wdata[sgc_pkg::THR_W-1:0]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            sgc_pkg::CSR_ENABLE:      cfg_in.enable          = csr_wdata[0];
            sgc_pkg::CSR_PRESS_THR:   cfg_in.press_sq        = thr_sq;
            sgc_pkg::CSR_RELEASE_THR: cfg_in.release_sq      = thr_sq;
            sgc_pkg::CSR_FIRST_DLY:   cfg_in.first_delay_us  = csr_wdata;
            sgc_pkg::CSR_REPEAT_DLY:  cfg_in.repeat_delay_us = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable          <= 1'b0;
         cfg_ff.press_sq        <= sgc_pkg::RST_PRESS_SQ;
         cfg_ff.release_sq      <= sgc_pkg::RST_RELEASE_SQ;
         cfg_ff.first_delay_us  <= sgc_pkg::RST_FIRST_DLY;
         cfg_ff.repeat_delay_us <= sgc_pkg::RST_REPEAT_DLY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hw/rtl/sgc_front.sv
// Input stage: squares the stick axes and finds the dominant axis of each item.
// Depends on sgc_pkg and sgc_req_if.
`default_nettype none

module sgc_front (
   input  wire logic          clock,
   input  wire logic          reset,
   sgc_req_if.sink            req_ch,
   input  wire logic          front_take,
   output logic               front_vld,
   output sgc_pkg::front_type front
);

   logic                         vld_ff;
   sgc_pkg::front_type           front_ff;
   sgc_pkg::front_type           front_in;
   logic signed [2*sgc_pkg::STICK_W-1:0] x_prod;
   logic signed [2*sgc_pkg::STICK_W-1:0] y_prod;
   logic [sgc_pkg::STICK_W:0]    x_ext;
   logic [sgc_pkg::STICK_W:0]    y_ext;
   logic [sgc_pkg::STICK_W:0]    x_abs;
   logic [sgc_pkg::STICK_W:0]    y_abs;
   logic                         accept;

   assign req_ch.ready = !vld_ff || front_take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      x_prod = (2*sgc_pkg::STICK_W)'(req_ch.stick_x) * (2*sgc_pkg::STICK_W)'(req_ch.stick_x);
      y_prod = (2*sgc_pkg::STICK_W)'(req_ch.stick_y) * (2*sgc_pkg::STICK_W)'(req_ch.stick_y);
      x_ext  = {req_ch.stick_x[sgc_pkg::STICK_W-1], req_ch.stick_x};
      y_ext  = {req_ch.stick_y[sgc_pkg::STICK_W-1], req_ch.stick_y};
      x_abs  = x_ext[sgc_pkg::STICK_W] ? (~x_ext + 1'b1) : x_ext;
      y_abs  = y_ext[sgc_pkg::STICK_W] ? (~y_ext + 1'b1) : y_ext;
      front_in.x_sq       = x_prod[sgc_pkg::SQ_W-1:0];
      front_in.y_sq       = y_prod[sgc_pkg::SQ_W-1:0];
      front_in.x_dom      = x_abs > y_abs;
      front_in.x_pos      = !req_ch.stick_x[sgc_pkg::STICK_W-1] && (req_ch.stick_x != '0);
      front_in.y_pos      = !req_ch.stick_y[sgc_pkg::STICK_W-1] && (req_ch.stick_y != '0);
      front_in.elapsed_us = req_ch.elapsed_us;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (accept) begin
         vld_ff <= 1'b1;
      end else if (front_take) begin
         vld_ff <= 1'b0;
      end
      if (accept) begin
         front_ff <= front_in;
      end
   end

   assign front_vld = vld_ff;
   assign front     = front_ff;

endmodule

`default_nettype wire

### hw/rtl/sgc_track.sv
// Direction tracking stage: hysteresis, autorepeat countdown, cursor state and result register.
// Depends on sgc_pkg and sgc_rsp_if.
`default_nettype none

module sgc_track (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               front_vld,
   input  wire sgc_pkg::front_type front,
   input  wire sgc_pkg::cfg_type   cfg,
   sgc_rsp_if.source               rsp_ch,
   output logic                    front_take
);

   typedef struct packed {
      logic [sgc_pkg::ROW_W-1:0] row;
      logic [sgc_pkg::COL_W-1:0] col;
   } pos_type;

   localparam logic [sgc_pkg::ROW_W-1:0] ROW_LAST = sgc_pkg::ROW_W'(sgc_pkg::GRID_ROWS - 1);
   localparam logic [sgc_pkg::COL_W-1:0] COL_LAST = sgc_pkg::COL_W'(sgc_pkg::GRID_COLS - 1);
   localparam logic [sgc_pkg::ROW_W-1:0] SVC_ROW  = sgc_pkg::ROW_W'(sgc_pkg::SERVICE_ROW);
   localparam logic SVC_ON = sgc_pkg::SERVICE_ROW < sgc_pkg::GRID_ROWS;

   function automatic pos_type step_pos(pos_type cur, sgc_pkg::dir_type dir);
      pos_type nxt;
      nxt = cur;
      case (dir)
         sgc_pkg::DIR_UP:    nxt.row = (cur.row == '0) ? ROW_LAST : cur.row - 1'b1;
         sgc_pkg::DIR_DOWN:  nxt.row = (cur.row == ROW_LAST) ? '0 : cur.row + 1'b1;
         sgc_pkg::DIR_LEFT:  nxt.col = (cur.col == '0) ? COL_LAST : cur.col - 1'b1;
         default:            nxt.col = (cur.col == COL_LAST) ? '0 : cur.col + 1'b1;
      endcase
      if (SVC_ON && nxt.row == SVC_ROW && nxt.col[0]) begin
         if (dir == sgc_pkg::DIR_LEFT) begin
            nxt.col = nxt.col - 1'b1;
         end else begin
            nxt.col = (nxt.col == COL_LAST) ? '0 : nxt.col + 1'b1;
         end
      end
      return nxt;
   endfunction

   pos_type                       pos_ff;
   pos_type                       pos_in;
   pos_type                       pos_step;
   sgc_pkg::dir_type              dir_ff;
   sgc_pkg::dir_type              dir_in;
   sgc_pkg::dir_type              dir_sel;
   logic [sgc_pkg::WAIT_W-1:0]    wait_ff;
   logic [sgc_pkg::WAIT_W-1:0]    wait_in;
   logic [sgc_pkg::WAIT_W:0]      wait_diff;
   logic [sgc_pkg::SQ_W:0]        mag_sq;
   logic                          expired;
   logic                          moved_in;
   logic                          rsp_vld_ff;
   logic                          moved_ff;
   pos_type                       rsp_pos_ff;
   sgc_pkg::dir_type              rsp_dir_ff;

   assign front_take = front_vld && (!rsp_vld_ff || rsp_ch.ready);

   always_comb begin
      mag_sq = {1'b0, front.x_sq} + {1'b0, front.y_sq};
      if (mag_sq >= {2'b0, cfg.press_sq}) begin
         if (front.x_dom) begin
            dir_sel = front.x_pos ? sgc_pkg::DIR_RIGHT : sgc_pkg::DIR_LEFT;
         end else begin
            dir_sel = front.y_pos ? sgc_pkg::DIR_DOWN : sgc_pkg::DIR_UP;
         end
      end else if (mag_sq < {2'b0, cfg.release_sq}) begin
         dir_sel = sgc_pkg::DIR_NONE;
      end else begin
         dir_sel = dir_ff;
      end

      wait_diff = {1'b0, wait_ff} - {2'b0, front.elapsed_us};
      expired   = wait_ff <= {1'b0, front.elapsed_us};
      pos_step  = step_pos(pos_ff, dir_sel);

      pos_in   = pos_ff;
      dir_in   = dir_ff;
      wait_in  = wait_ff;
      moved_in = 1'b0;
      if (cfg.enable) begin
         if (dir_sel == sgc_pkg::DIR_NONE) begin
            dir_in  = sgc_pkg::DIR_NONE;
            wait_in = '0;
         end else if (dir_sel != dir_ff) begin
            dir_in   = dir_sel;
            wait_in  = {1'b0, cfg.first_delay_us};
            pos_in   = pos_step;
            moved_in = 1'b1;
         end else if (expired) begin
            wait_in  = {1'b0, cfg.repeat_delay_us};
            pos_in   = pos_step;
            moved_in = 1'b1;
         end else begin
            wait_in = wait_diff[sgc_pkg::WAIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff.row <= sgc_pkg::RST_ROW;
         pos_ff.col <= sgc_pkg::RST_COL;
         dir_ff     <= sgc_pkg::DIR_NONE;
         wait_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (front_take) begin
            pos_ff     <= pos_in;
            dir_ff     <= dir_in;
            wait_ff    <= wait_in;
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
      if (front_take) begin
         rsp_pos_ff <= pos_in;
         rsp_dir_ff <= dir_in;
         moved_ff   <= moved_in;
      end
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.cursor_row     = rsp_pos_ff.row;
   assign rsp_ch.cursor_col     = rsp_pos_ff.col;
   assign rsp_ch.moved          = moved_ff;
   assign rsp_ch.held_direction = rsp_dir_ff;

endmodule

`default_nettype wire

### hw/rtl/stick_grid_cursor_autorepeat_core.sv
// Top level of the stick grid cursor autorepeat core.
// Depends on sgc_pkg, sgc_if, sgc_csr, sgc_front and sgc_track.
//
// Takes one stick item per clock cycle unless results stall, and returns exactly one
// result item per sample: the input stage registers the squared axes and the dominant
// axis, and the tracking stage applies hysteresis, the autorepeat countdown and the grid
// wrap while updating the cursor state. A stalled result holds the tracking stage,
// and the input stage still takes one more item. There is no clearing pass after reset.
// The user must write configuration through csr_we, csr_index and csr_wdata only while no
// item is in flight; the core does not enforce it. The thresholds are squared as written.
`default_nettype none

module stick_grid_cursor_autorepeat_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sgc_req_if.sink                              req_ch,
   sgc_rsp_if.source                            rsp_ch,
   input  wire logic                            csr_we,
   input  wire logic [sgc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [sgc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   sgc_pkg::cfg_type   cfg;
   sgc_pkg::front_type front;
   logic               front_vld;
   logic               front_take;

   sgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sgc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .front_take (front_take),
      .front_vld  (front_vld),
      .front      (front)
   );

   sgc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .front_vld  (front_vld),
      .front      (front),
      .cfg        (cfg),
      .rsp_ch     (rsp_ch),
      .front_take (front_take)
   );

`ifndef NO_ASSERTIONS
   a_moved_has_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.moved) |-> (rsp_ch.held_direction != sgc_pkg::DIR_NONE))
      else $error("moved item reports no held direction");

   a_disabled_still: assert property (@(posedge clock) disable iff (reset)
      (front_take && !cfg.enable) |=> !rsp_ch.moved)
      else $error("cursor moved while disabled");

   a_cursor_on_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((32'(rsp_ch.cursor_row) < sgc_pkg::GRID_ROWS) &&
                        (32'(rsp_ch.cursor_col) < sgc_pkg::GRID_COLS)))
      else $error("cursor left the grid");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && front_vld) |-> front_take)
      else $error("input stage overwritten before its item was taken");
`endif

endmodule

`default_nettype wire

### verif/stick_grid_cursor_autorepeat_core_test.sv
// Self-checking testbench for stick_grid_cursor_autorepeat_core: drives stick items through
// sgc_req_if, predicts each cursor result, and checks it on sgc_rsp_if under random stalls.
// Depends on sgc_pkg, sgc_if and the core RTL.
`timescale 1ns / 1ps

module stick_grid_cursor_autorepeat_core_test;
   import sgc_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int LONG_STALL  = 300;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_REG = 3'd7;

   typedef struct {
      logic signed [STICK_W-1:0] stick_x;
      logic signed [STICK_W-1:0] stick_y;
      logic [TIME_W-1:0]         elapsed_us;
   } stick_sample_type;

   typedef struct {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             moved;
      dir_type          dir;
   } cursor_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sgc_req_if req_bus();
   sgc_rsp_if rsp_bus();

   stick_grid_cursor_autorepeat_core dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   stick_sample_type  pending_samples[$];
   cursor_result_type expected_cursor[$];
   stick_sample_type  next_sample;
   cursor_result_type want;

   int     cfg_enable    = 0;
   int     cfg_press     = 16384;
   int     cfg_release   = 11469;
   int     cfg_first_us  = 350000;
   int     cfg_repeat_us = 120000;
   int     cur_row       = 1;
   int     cur_col       = 0;
   dir_type held_dir     = DIR_NONE;
   longint wait_left_us  = 0;

   int send_idle_pct;
   int recv_idle_pct;
   int samples_made = 0;
   int fail_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit stall_arm = 0;
   bit stall_used = 0;

   always #2 clock = ~clock;

   function automatic void step_grid(input dir_type d);
      int dr, dc, r, c;
      dr = 0;
      dc = 0;
      case (d)
         DIR_UP: dr = -1;
         DIR_DOWN: dr = 1;
         DIR_LEFT: dc = -1;
         default: dc = 1;
      endcase
      r = (cur_row + dr + GRID_ROWS) % GRID_ROWS;
      c = (cur_col + dc + GRID_COLS) % GRID_COLS;
      if (r == SERVICE_ROW && c % 2 != 0) begin
         c = (c + ((dc >= 0) ? 1 : -1) + GRID_COLS) % GRID_COLS;
      end
      cur_row = r;
      cur_col = c;
   endfunction

   function automatic cursor_result_type track_sample(input logic signed [STICK_W-1:0] sx,
         input logic signed [STICK_W-1:0] sy, input logic [TIME_W-1:0] el);
      longint xs, ys, mag_sq, ax, ay, left;
      dir_type d;
      cursor_result_type res;
      res.moved = 1'b0;
      if (cfg_enable != 0) begin
         xs = sx;
         ys = sy;
         mag_sq = xs * xs + ys * ys;
         ax = (xs < 0) ? -xs : xs;
         ay = (ys < 0) ? -ys : ys;
         if (mag_sq >= longint'(cfg_press) * cfg_press) begin
            if (ax > ay) d = (xs > 0) ? DIR_RIGHT : DIR_LEFT;
            else d = (ys > 0) ? DIR_DOWN : DIR_UP;
         end else if (mag_sq < longint'(cfg_release) * cfg_release) begin
            d = DIR_NONE;
         end else begin
            d = held_dir;
         end
         if (d == DIR_NONE) begin
            held_dir = DIR_NONE;
            wait_left_us = 0;
         end else if (d != held_dir) begin
            held_dir = d;
            wait_left_us = cfg_first_us;
            step_grid(d);
            res.moved = 1'b1;
         end else begin
            left = wait_left_us - longint'(el);
            if (left <= 0) begin
               wait_left_us = cfg_repeat_us;
               step_grid(d);
               res.moved = 1'b1;
            end else begin
               wait_left_us = left;
            end
         end
      end
      res.row = cur_row[ROW_W-1:0];
      res.col = cur_col[COL_W-1:0];
      res.dir = held_dir;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_cursor.insert(expected_cursor.size(),
                                   track_sample(req_bus.stick_x, req_bus.stick_y,
                                                req_bus.elapsed_us));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_sample = pending_samples.pop_front();
               req_bus.stick_x    <= next_sample.stick_x;
               req_bus.stick_y    <= next_sample.stick_y;
               req_bus.elapsed_us <= next_sample.elapsed_us;
               req_bus.valid      <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string field, input logic [3:0] exp_val,
                              input logic [3:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_cursor.size() == 0) begin
               $error("result item with no expectation waiting");
               fail_count++;
            end else begin
               want = expected_cursor.pop_front();
               check_field("cursor_row", want.row, rsp_bus.cursor_row);
               check_field("cursor_col", want.col, rsp_bus.cursor_col);
               check_field("moved", want.moved, rsp_bus.moved);
               check_field("held_direction", want.dir, rsp_bus.held_direction);
            end
         end
         if (stall_arm && !stall_used) begin
            stall_left = LONG_STALL;
            stall_used = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ENABLE: cfg_enable = value[0];
         CSR_PRESS_THR: cfg_press = value[THR_W-1:0];
         CSR_RELEASE_THR: cfg_release = value[THR_W-1:0];
         CSR_FIRST_DLY: cfg_first_us = value[TIME_W-1:0];
         CSR_REPEAT_DLY: cfg_repeat_us = value[TIME_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_cursor.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic push_sample(input int x, input int y, input int el);
      stick_sample_type s;
      s.stick_x = x[STICK_W-1:0];
      s.stick_y = y[STICK_W-1:0];
      s.elapsed_us = el[TIME_W-1:0];
      pending_samples.insert(pending_samples.size(), s);
      samples_made++;
   endtask

   task automatic push_toward(input dir_type d, input int lo, input int hi, input bit with_off,
                              input int el);
      int main_mag, off_mag, main_v, off_v;
      main_mag = $urandom_range(hi, lo);
      if (!with_off) off_mag = 0;
      else if (d == DIR_LEFT || d == DIR_RIGHT) off_mag = (main_mag == 0) ? 0 : $urandom_range(main_mag - 1);
      else off_mag = $urandom_range(main_mag);
      off_v = $urandom_range(1) ? -off_mag : off_mag;
      main_v = main_mag;
      if (d == DIR_UP || d == DIR_LEFT) begin
         main_v = (main_mag == 32767 && $urandom_range(1)) ? -32768 : -main_mag;
      end
      if (d == DIR_LEFT || d == DIR_RIGHT) push_sample(main_v, off_v, el);
      else push_sample(off_v, main_v, el);
   endtask

   function automatic int pick_elapsed(input int time_scale);
      int r;
      r = $urandom_range(9);
      if (r == 0) return $urandom_range(1000000);
      if (r < 3) return $urandom_range(20);
      return $urandom_range(time_scale);
   endfunction

   task automatic feed_strokes(input int count, input int time_scale);
      int stop_at, len, pick, lim;
      dir_type d;
      @(negedge clock);
      stop_at = samples_made + count;
      while (samples_made < stop_at) begin
         if ($urandom_range(6) == 0) begin
            repeat ($urandom_range(3, 1)) push_sample($urandom, $urandom, $urandom_range(1000000));
         end else begin
            d = dir_type'($urandom_range(3));
            len = $urandom_range(12, 1);
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(19);
               if (pick < 15) begin
                  push_toward(d, cfg_press, 32767, 1'b1, pick_elapsed(time_scale));
               end else if (pick < 18 && cfg_press > cfg_release) begin
                  push_toward(d, cfg_release, cfg_press - 1, 1'b0, pick_elapsed(time_scale));
               end else begin
                  push_sample($urandom, $urandom, pick_elapsed(time_scale));
               end
            end
            if ($urandom_range(4) != 0) begin
               lim = cfg_release / 2;
               repeat ($urandom_range(2, 1)) begin
                  push_sample(int'($urandom_range(2 * lim)) - lim,
                              int'($urandom_range(2 * lim)) - lim, pick_elapsed(time_scale));
               end
            end
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.stick_x = '0;
      req_bus.stick_y = '0;
      req_bus.elapsed_us = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 18;
      recv_idle_pct = 76;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // While disabled, items must leave the cursor untouched.
      @(negedge clock);
      push_sample(0, 0, 0);
      push_sample(32767, -32768, 1000000);
      wait_idle();
      write_csr(CSR_ENABLE, 20'd1);

      @(negedge clock);
      push_sample(32767, 0, 0);
      push_sample(32767, 0, 1000000);
      push_sample(32767, 0, 100000);
      push_sample(-32768, 0, 0);
      push_sample(0, -32768, 1);
      push_sample(-32768, -32768, 5);
      push_sample(0, 32767, 0);
      push_sample(20000, 20000, 0);
      push_sample(12000, 0, 500000);
      push_sample(0, 0, 0);
      push_sample(12000, 0, 0);
      push_sample(-1, 1, 524288);
      repeat (3) begin
         push_sample(0, 20000, 3);
         push_sample(0, 0, 3);
      end
      repeat (2) begin
         push_sample(20000, 0, 0);
         push_sample(0, 0, 0);
      end
      push_sample(-20000, 0, 0);
      push_sample(0, 0, 0);

      feed_strokes(120, 60000);
      wait_idle();
      feed_strokes(120, 60000);
      wait_idle();

      write_csr(CSR_PRESS_THR, 20'd32767);
      write_csr(CSR_RELEASE_THR, 20'd32767);
      write_csr(CSR_FIRST_DLY, 20'd1000000);
      write_csr(CSR_REPEAT_DLY, 20'd1000000);
      feed_strokes(240, 400000);
      wait_idle();

      set_idling(76, 18);
      write_csr(CSR_PRESS_THR, 20'd0);
      write_csr(CSR_RELEASE_THR, 20'd0);
      write_csr(CSR_FIRST_DLY, 20'd0);
      write_csr(CSR_REPEAT_DLY, 20'd0);
      // A zero stick with a zero press threshold is a tie and counts as up.
      @(negedge clock);
      repeat (3) push_sample(0, 0, 7);
      feed_strokes(240, 20);
      wait_idle();

      write_csr(CSR_PRESS_THR, 20'd8000);
      write_csr(CSR_RELEASE_THR, 20'd20000);
      write_csr(CSR_FIRST_DLY, 20'd5000);
      write_csr(CSR_REPEAT_DLY, 20'd1500);
      feed_strokes(240, 3000);
      wait_idle();

      set_idling(0, 0);
      write_csr(CSR_PRESS_THR, 20'hF8000 | 20'd20000);
      write_csr(CSR_RELEASE_THR, 20'd6000);
      write_csr(CSR_FIRST_DLY, 20'd200000);
      write_csr(CSR_REPEAT_DLY, 20'd50000);
      write_csr(CSR_NO_REG, 20'hFFFFF);
      @(negedge clock);
      stall_arm = 1'b1;
      feed_strokes(240, 80000);
      wait_idle();

      write_csr(CSR_ENABLE, 20'd0);
      feed_strokes(30, 100000);
      wait_idle();
      write_csr(CSR_ENABLE, 20'd1);
      write_csr(CSR_PRESS_THR, CSR_DATA_W'($urandom_range(32767)));
      write_csr(CSR_RELEASE_THR, CSR_DATA_W'($urandom_range(32767)));
      write_csr(CSR_FIRST_DLY, CSR_DATA_W'($urandom_range(1000000)));
      write_csr(CSR_REPEAT_DLY, CSR_DATA_W'($urandom_range(1000000)));
      feed_strokes(210, cfg_repeat_us / 2 + 1);
      wait_idle();

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
